// ===== hdl/lpc_pkg.sv =====
`timescale 1ns / 1ps
package lpc_pkg;

  localparam int unsigned MoneyW   = 48;
  localparam int unsigned RateW    = 32;
  localparam int unsigned KW       = RateW + 1;
  localparam int unsigned LoW      = MoneyW / 2;
  localparam int unsigned HiW      = MoneyW - LoW;
  localparam int unsigned AdjW     = MoneyW + KW;
  localparam int unsigned ProdW    = MoneyW + RateW;
  localparam int unsigned NumW     = AdjW + 1;
  localparam int unsigned PosW     = $clog2(NumW);
  localparam int unsigned FracW    = 56;
  localparam int unsigned LogW     = PosW + FracW;
  localparam int unsigned MantW    = 64;
  localparam int unsigned MantTop  = 62;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned SumDivW  = MoneyW + 1 + ScaleW;
  localparam int unsigned LogDivW  = LogW + ScaleW;
  localparam int unsigned DivW     = (SumDivW > LogDivW) ? SumDivW : LogDivW;
  localparam int unsigned DlMagW   = 61;
  localparam int unsigned DisW     = (MoneyW > DlMagW) ? MoneyW : DlMagW;
  localparam int unsigned NumLanes = 3;
  localparam int unsigned LaneNum  = 0;
  localparam int unsigned LaneDen  = 1;
  localparam int unsigned LaneBase = 2;
  localparam int unsigned RateFrac = 30;

  localparam logic [1:0] TimingEnd   = 2'd0;
  localparam logic [1:0] TimingBegin = 2'd1;

  localparam logic signed [RateW-1:0] RateMinusOne = 32'shC000_0000;
  localparam logic signed [KW-1:0]    RateOne      = 33'sh0_4000_0000;
  localparam logic [LogW-1:0]         BaseLog      = LogW'(RateFrac) << FracW;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StValue = 2'd1,
    StDiv0  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [RateW-1:0]  rate;
    logic signed [MoneyW-1:0] payment;
    logic signed [MoneyW-1:0] present_value;
    logic signed [MoneyW-1:0] future_value;
    logic [1:0]               timing;
  } lpc_in_t;

  typedef struct packed {
    logic signed [MoneyW-1:0] periods;
    status_e                  status;
  } lpc_out_t;

  typedef struct packed {
    status_e           status;
    logic              zero_path;
    logic              zneg;
    logic [MoneyW:0]   sum_abs;
    logic [MoneyW-1:0] pmt_abs;
  } lpc_side_t;

  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [MantW-1:0] mant;
    logic [FracW-1:0] frac;
  } lpc_lane_t;

endpackage

// ===== hdl/loan_period_count_core.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o    in_data_i   (lpc_in_t)
// out       output     out_valid_o / out_ready_i  out_data_o  (lpc_out_t)
//
// one item per clock while the skid register is empty; the pipeline holds 8 front stages,
// 112 log stages (56 squaring steps, two each), a log difference stage, an operand
// select stage, 79 divider bit stages, a saturation stage and the output register
// reset clears the valid bits of every stage and of the output and skid registers
// a result not taken moves into a skid register; only a full skid stalls the pipeline
module loan_period_count_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lpc_pkg::lpc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lpc_pkg::lpc_out_t out_data_o
);
  import lpc_pkg::*;

  logic                     en;
  logic                     front_valid, log_valid, div_valid;
  lpc_lane_t [NumLanes-1:0] front_lanes, log_lanes;
  lpc_side_t                front_side, log_side;
  lpc_out_t                 div_data;

  logic     out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  lpc_out_t out_data_q, out_data_d, skid_data_q, skid_data_d;
  logic     take, push;

  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  lpc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (front_valid),
    .lanes_o (front_lanes),
    .side_o  (front_side)
  );

  lpc_log_unit u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .lanes_i (front_lanes),
    .side_i  (front_side),
    .valid_o (log_valid),
    .lanes_o (log_lanes),
    .side_o  (log_side)
  );

  lpc_div_unit u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (log_valid),
    .lanes_i (log_lanes),
    .side_i  (log_side),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  assign take = out_valid_q && out_ready_i;
  assign push = en && div_valid;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    priority if (skid_valid_q) begin
      if (take) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || take) begin
        out_valid_d = 1'b1;
        out_data_d  = div_data;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = div_data;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output register is empty");

  a_skid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_ready_i |=> skid_valid_q && $stable(skid_data_q))
    else $error("skid result lost or changed without a transfer");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StOk |-> out_data_o.periods == '0)
    else $error("nonzero period count on an error status");

endmodule

// ===== hdl/lpc_front.sv =====
`timescale 1ns / 1ps
module lpc_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  logic                                      valid_i,
  input  lpc_pkg::lpc_in_t                          data_i,
  output logic                                      valid_o,
  output lpc_pkg::lpc_lane_t [lpc_pkg::NumLanes-1:0] lanes_o,
  output lpc_pkg::lpc_side_t                        side_o
);
  import lpc_pkg::*;

  localparam int unsigned Depth     = 8;
  localparam int unsigned ChunkW    = 8;
  localparam int unsigned ChunkPosW = $clog2(ChunkW);
  localparam int unsigned Chunks    = (NumW + ChunkW - 1) / ChunkW;
  localparam int unsigned PadW      = Chunks * ChunkW;
  localparam int unsigned WideW     = NumW + MantTop;

  function automatic logic [ChunkPosW-1:0] msb_chunk(input logic [ChunkW-1:0] v);
    logic [ChunkPosW-1:0] r;
    r = '0;
    for (int i = 1; i < ChunkW; i++) begin
      if (v[i]) r = ChunkPosW'(i);
    end
    return r;
  endfunction

  logic [Depth-1:0] v_q;

  // stage 1: decode
  logic signed [RateW-1:0]  r1_q;
  logic signed [KW-1:0]     k1_q, k1_d, rate_k;
  logic [KW-1:0]            base1_q, base1_d;
  logic signed [MoneyW-1:0] pmt1_q, pv1_q, fv1_q;
  logic signed [MoneyW:0]   sum1_q, sum1_d;
  logic                     bad1_q, rz1_q;

  // stage 2: partial products
  logic signed [LoW+KW:0]      ppl2_q, ppl2_d;
  logic signed [HiW+KW-1:0]    pph2_q, pph2_d;
  logic signed [LoW+RateW:0]   fvl2_q, fvl2_d, pvl2_q, pvl2_d;
  logic signed [HiW+RateW-1:0] fvh2_q, fvh2_d, pvh2_q, pvh2_d;
  logic                        bad2_q, rz2_q, pmtz2_q, zneg2_q;
  logic [MoneyW:0]             sabs2_q, sabs2_d;
  logic [MoneyW-1:0]           pabs2_q, pabs2_d;
  logic [KW-1:0]               base2_q;

  // stage 3: products
  logic signed [AdjW-1:0]  adj3_q, adj3_d;
  logic signed [ProdW-1:0] fvr3_q, fvr3_d, pvr3_q, pvr3_d;
  lpc_side_t               side3_q, side3_d;
  logic [KW-1:0]           base3_q;

  // stage 4: numerator and denominator
  logic signed [NumW-1:0] num4_q, den4_q;
  lpc_side_t              side4_q;
  logic [KW-1:0]          base4_q;

  // stage 5: checks and magnitudes
  lpc_side_t                         side5_q, side5_d;
  logic [NumLanes-1:0][NumW-1:0]     x5_q, x5_d;

  // stage 6 to 8: leading one search and normalize
  logic [NumLanes-1:0][Chunks-1:0]                nz6_q, nz6_d;
  logic [NumLanes-1:0][Chunks-1:0][ChunkPosW-1:0] lo6_q, lo6_d;
  logic [NumLanes-1:0][NumW-1:0]                  x6_q, x7_q;
  lpc_side_t                                      side6_q, side7_q, side8_q;
  logic [NumLanes-1:0][PosW-1:0]                  pos7_q, pos7_d;
  lpc_lane_t [NumLanes-1:0]                       lanes8_q, lanes8_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Depth-2:0], valid_i};
    end
  end

  always_comb begin
    rate_k  = (data_i.timing == TimingBegin) ?
              $signed({data_i.rate[RateW-1], data_i.rate}) : '0;
    k1_d    = RateOne + rate_k;
    base1_d = RateOne + $signed({data_i.rate[RateW-1], data_i.rate});
    sum1_d  = $signed({data_i.present_value[MoneyW-1], data_i.present_value})
            + $signed({data_i.future_value[MoneyW-1], data_i.future_value});
  end

  always_comb begin
    ppl2_d  = $signed({1'b0, pmt1_q[LoW-1:0]}) * k1_q;
    pph2_d  = $signed(pmt1_q[MoneyW-1:LoW]) * k1_q;
    fvl2_d  = $signed({1'b0, fv1_q[LoW-1:0]}) * r1_q;
    fvh2_d  = $signed(fv1_q[MoneyW-1:LoW]) * r1_q;
    pvl2_d  = $signed({1'b0, pv1_q[LoW-1:0]}) * r1_q;
    pvh2_d  = $signed(pv1_q[MoneyW-1:LoW]) * r1_q;
    sabs2_d = sum1_q[MoneyW] ? (~sum1_q + 1'b1) : sum1_q;
    pabs2_d = pmt1_q[MoneyW-1] ? (~pmt1_q + 1'b1) : pmt1_q;
  end

  always_comb begin
    adj3_d = $signed({pph2_q, {LoW{1'b0}}}) + ppl2_q;
    fvr3_d = $signed({fvh2_q, {LoW{1'b0}}}) + fvl2_q;
    pvr3_d = $signed({pvh2_q, {LoW{1'b0}}}) + pvl2_q;
    side3_d.zero_path = rz2_q;
    side3_d.zneg      = zneg2_q;
    side3_d.sum_abs   = sabs2_q;
    side3_d.pmt_abs   = pabs2_q;
    priority if (bad2_q) begin
      side3_d.status = StValue;
    end else if (rz2_q && pmtz2_q) begin
      side3_d.status = StDiv0;
    end else begin
      side3_d.status = StOk;
    end
  end

  always_comb begin
    side5_d = side4_q;
    if (side4_q.status == StOk && !side4_q.zero_path) begin
      priority if (den4_q == '0) begin
        side5_d.status = StDiv0;
      end else if (num4_q == '0 || (num4_q[NumW-1] != den4_q[NumW-1])) begin
        side5_d.status = StValue;
      end
    end
    x5_d[LaneNum]  = num4_q[NumW-1] ? (~num4_q + 1'b1) : num4_q;
    x5_d[LaneDen]  = den4_q[NumW-1] ? (~den4_q + 1'b1) : den4_q;
    x5_d[LaneBase] = {{(NumW-KW){1'b0}}, base4_q};
  end

  always_comb begin
    logic [PadW-1:0] xp;
    for (int l = 0; l < NumLanes; l++) begin
      xp = PadW'(x5_q[l]);
      for (int c = 0; c < Chunks; c++) begin
        nz6_d[l][c] = |xp[c*ChunkW +: ChunkW];
        lo6_d[l][c] = msb_chunk(xp[c*ChunkW +: ChunkW]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      pos7_d[l] = '0;
      for (int c = 0; c < Chunks; c++) begin
        if (nz6_q[l][c]) pos7_d[l] = PosW'(c * ChunkW) + PosW'(lo6_q[l][c]);
      end
    end
  end

  always_comb begin
    logic [WideW-1:0] wide;
    for (int l = 0; l < NumLanes; l++) begin
      wide              = {x7_q[l], {MantTop{1'b0}}} >> pos7_q[l];
      lanes8_d[l].pos   = pos7_q[l];
      lanes8_d[l].mant  = wide[MantW-1:0];
      lanes8_d[l].frac  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q    <= data_i.rate;
      k1_q    <= k1_d;
      base1_q <= base1_d;
      pmt1_q  <= data_i.payment;
      pv1_q   <= data_i.present_value;
      fv1_q   <= data_i.future_value;
      sum1_q  <= sum1_d;
      bad1_q  <= (data_i.timing != TimingEnd && data_i.timing != TimingBegin)
                 || (data_i.rate <= RateMinusOne);
      rz1_q   <= (data_i.rate == '0);

      ppl2_q  <= ppl2_d;
      pph2_q  <= pph2_d;
      fvl2_q  <= fvl2_d;
      fvh2_q  <= fvh2_d;
      pvl2_q  <= pvl2_d;
      pvh2_q  <= pvh2_d;
      bad2_q  <= bad1_q;
      rz2_q   <= rz1_q;
      pmtz2_q <= (pmt1_q == '0);
      zneg2_q <= (sum1_q[MoneyW] == pmt1_q[MoneyW-1]);
      sabs2_q <= sabs2_d;
      pabs2_q <= pabs2_d;
      base2_q <= base1_q;

      adj3_q  <= adj3_d;
      fvr3_q  <= fvr3_d;
      pvr3_q  <= pvr3_d;
      side3_q <= side3_d;
      base3_q <= base2_q;

      num4_q  <= adj3_q - fvr3_q;
      den4_q  <= adj3_q + pvr3_q;
      side4_q <= side3_q;
      base4_q <= base3_q;

      side5_q <= side5_d;
      x5_q    <= x5_d;

      nz6_q   <= nz6_d;
      lo6_q   <= lo6_d;
      x6_q    <= x5_q;
      side6_q <= side5_q;

      pos7_q  <= pos7_d;
      x7_q    <= x6_q;
      side7_q <= side6_q;

      lanes8_q <= lanes8_d;
      side8_q  <= side7_q;
    end
  end

  assign valid_o = v_q[Depth-1];
  assign lanes_o = lanes8_q;
  assign side_o  = side8_q;

endmodule

// ===== hdl/lpc_log_unit.sv =====
`timescale 1ns / 1ps
module lpc_log_unit (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  logic                                      valid_i,
  input  lpc_pkg::lpc_lane_t [lpc_pkg::NumLanes-1:0] lanes_i,
  input  lpc_pkg::lpc_side_t                        side_i,
  output logic                                      valid_o,
  output lpc_pkg::lpc_lane_t [lpc_pkg::NumLanes-1:0] lanes_o,
  output lpc_pkg::lpc_side_t                        side_o
);
  import lpc_pkg::*;

  localparam int unsigned HalfW = MantW / 2;
  localparam int unsigned SqW   = 2 * MantW;

  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [FracW-1:0] frac;
    logic [MantW-1:0] p11;
    logic [MantW-1:0] p10;
    logic [MantW-1:0] p00;
  } sq_t;

  wire [FracW:0]                 valid_c;
  wire lpc_lane_t [NumLanes-1:0] lanes_c [FracW+1];
  wire lpc_side_t                side_c [FracW+1];

  assign valid_c[0] = valid_i;
  assign lanes_c[0] = lanes_i;
  assign side_c[0]  = side_i;

  for (genvar s = 0; s < FracW; s++) begin : g_step
    logic                     va_q, vb_q;
    sq_t [NumLanes-1:0]       sa_q, sa_d;
    lpc_lane_t [NumLanes-1:0] sb_q, sb_d;
    lpc_side_t                side_a_q, side_b_q;

    // partial products of the mantissa square
    always_comb begin
      logic [HalfW-1:0] hi;
      logic [HalfW-1:0] lo;
      for (int l = 0; l < NumLanes; l++) begin
        hi            = lanes_c[s][l].mant[MantW-1:HalfW];
        lo            = lanes_c[s][l].mant[HalfW-1:0];
        sa_d[l].pos   = lanes_c[s][l].pos;
        sa_d[l].frac  = lanes_c[s][l].frac;
        sa_d[l].p11   = MantW'(hi) * MantW'(hi);
        sa_d[l].p10   = MantW'(hi) * MantW'(lo);
        sa_d[l].p00   = MantW'(lo) * MantW'(lo);
      end
    end

    // sum, renormalize, take one fraction bit
    always_comb begin
      logic [SqW-1:0]   sq;
      logic [MantW-1:0] m2;
      for (int l = 0; l < NumLanes; l++) begin
        sq = {sa_q[l].p11, {MantW{1'b0}}}
           + (SqW'(sa_q[l].p10) << (HalfW + 1))
           + SqW'(sa_q[l].p00);
        m2            = sq[MantTop+MantW-1:MantTop];
        sb_d[l].pos   = sa_q[l].pos;
        sb_d[l].frac  = {sa_q[l].frac[FracW-2:0], m2[MantW-1]};
        sb_d[l].mant  = m2[MantW-1] ? (m2 >> 1) : m2;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q <= 1'b0;
        vb_q <= 1'b0;
      end else if (en_i) begin
        va_q <= valid_c[s];
        vb_q <= va_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sa_q     <= sa_d;
        side_a_q <= side_c[s];
        sb_q     <= sb_d;
        side_b_q <= side_a_q;
      end
    end

    assign valid_c[s+1] = vb_q;
    assign lanes_c[s+1] = sb_q;
    assign side_c[s+1]  = side_b_q;
  end

  assign valid_o = valid_c[FracW];
  assign lanes_o = lanes_c[FracW];
  assign side_o  = side_c[FracW];

endmodule

// ===== hdl/lpc_div_unit.sv =====
`timescale 1ns / 1ps
module lpc_div_unit (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  logic                                      valid_i,
  input  lpc_pkg::lpc_lane_t [lpc_pkg::NumLanes-1:0] lanes_i,
  input  lpc_pkg::lpc_side_t                        side_i,
  output logic                                      valid_o,
  output lpc_pkg::lpc_out_t                         data_o
);
  import lpc_pkg::*;

  localparam logic [DivW-1:0]   QMaxPos = {{(DivW-MoneyW+1){1'b0}}, {(MoneyW-1){1'b1}}};
  localparam logic [DivW-1:0]   QMinMag = QMaxPos + 1'b1;
  localparam logic [MoneyW-1:0] MaxPos  = {1'b0, {(MoneyW-1){1'b1}}};
  localparam logic [MoneyW-1:0] MinNeg  = {1'b1, {(MoneyW-1){1'b0}}};

  // log difference stage
  logic                  v0_q;
  logic signed [LogW:0]  nl0_q, nl0_d, dl0_q, dl0_d;
  lpc_side_t             side0_q;

  // operand select stage
  logic                  v1_q;
  logic [DivW-1:0]       z1_q, z1_d;
  logic [DisW-1:0]       d1_q, d1_d;
  logic                  neg1_q, neg1_d;
  status_e               st1_q, st1_d;

  always_comb begin
    nl0_d = $signed({1'b0, lanes_i[LaneNum].pos, lanes_i[LaneNum].frac})
          - $signed({1'b0, lanes_i[LaneDen].pos, lanes_i[LaneDen].frac});
    dl0_d = $signed({1'b0, lanes_i[LaneBase].pos, lanes_i[LaneBase].frac})
          - $signed({1'b0, BaseLog});
  end

  always_comb begin
    logic [LogW:0] nl_abs;
    logic [LogW:0] dl_abs;
    nl_abs = nl0_q[LogW] ? (~nl0_q + 1'b1) : nl0_q;
    dl_abs = dl0_q[LogW] ? (~dl0_q + 1'b1) : dl0_q;
    st1_d  = side0_q.status;
    if (side0_q.zero_path) begin
      z1_d   = DivW'({side0_q.sum_abs, {ScaleW{1'b0}}});
      d1_d   = DisW'(side0_q.pmt_abs);
      neg1_d = side0_q.zneg;
    end else begin
      z1_d   = DivW'({nl_abs[LogW-1:0], {ScaleW{1'b0}}});
      d1_d   = DisW'(dl_abs);
      neg1_d = nl0_q[LogW] != dl0_q[LogW];
      if (side0_q.status == StOk && dl0_q == '0) st1_d = StDiv0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nl0_q   <= nl0_d;
      dl0_q   <= dl0_d;
      side0_q <= side_i;
      z1_q    <= z1_d;
      d1_q    <= d1_d;
      neg1_q  <= neg1_d;
      st1_q   <= st1_d;
    end
  end

  // restoring division, one quotient bit per stage
  wire [DivW:0]        valid_c;
  wire [DisW-1:0]      rem_c [DivW+1];
  wire [DivW-1:0]      z_c   [DivW+1];
  wire [DisW-1:0]      d_c   [DivW+1];
  wire [DivW:0]        neg_c;
  wire status_e        st_c  [DivW+1];

  assign valid_c[0] = v1_q;
  assign rem_c[0]   = '0;
  assign z_c[0]     = z1_q;
  assign d_c[0]     = d1_q;
  assign neg_c[0]   = neg1_q;
  assign st_c[0]    = st1_q;

  for (genvar i = 0; i < DivW; i++) begin : g_bit
    logic            v_q;
    logic [DisW-1:0] rem_q, rem_d;
    logic [DivW-1:0] z_q, z_d;
    logic [DisW-1:0] d_q;
    logic            neg_q;
    status_e         st_q;

    always_comb begin
      logic [DisW:0] trial;
      logic          ge;
      trial = {rem_c[i], z_c[i][DivW-1]};
      ge    = trial >= {1'b0, d_c[i]};
      rem_d = ge ? DisW'(trial - {1'b0, d_c[i]}) : DisW'(trial);
      z_d   = {z_c[i][DivW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= valid_c[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= rem_d;
        z_q   <= z_d;
        d_q   <= d_c[i];
        neg_q <= neg_c[i];
        st_q  <= st_c[i];
      end
    end

    assign valid_c[i+1] = v_q;
    assign rem_c[i+1]   = rem_q;
    assign z_c[i+1]     = z_q;
    assign d_c[i+1]     = d_q;
    assign neg_c[i+1]   = neg_q;
    assign st_c[i+1]    = st_q;
  end

  // saturate and sign
  logic      vs_q;
  lpc_out_t  res_q, res_d;

  always_comb begin
    logic [DivW-1:0] q;
    q            = z_c[DivW];
    res_d.status = st_c[DivW];
    priority if (st_c[DivW] != StOk) begin
      res_d.periods = '0;
    end else if (!neg_c[DivW]) begin
      res_d.periods = (q > QMaxPos) ? MaxPos : q[MoneyW-1:0];
    end else begin
      res_d.periods = (q > QMinMag) ? MinNeg : (~q[MoneyW-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (en_i) begin
      vs_q <= valid_c[DivW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = vs_q;
  assign data_o  = res_q;

endmodule
